[hdl/lzw_variable_width_decoder_top_assert.svh]
// assertion macros for the lzw decoder checker
`ifndef LZW_VARIABLE_WIDTH_DECODER_TOP_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define LVWD_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("lvwd assertion failed");

// next-cycle implication
`define LVWD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lvwd assertion failed");

`endif

[hdl/lvwd_pkg.sv]
// shared types, codes and constants of the lzw decoder
package lvwd_pkg;

  localparam int TableNodesDef  = 4096;
  localparam int MaxCodeBitsDef = 12;
  localparam int CodeW          = 12;
  localparam int StackDepth     = 4096;
  localparam int StackAw        = 12;
  localparam int CountW         = 13;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_STRIP = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NEED    = 3'd1;
  localparam logic [2:0] ST_END     = 3'd2;
  localparam logic [2:0] ST_NOCLEAR = 3'd3;
  localparam logic [2:0] ST_PENDING = 3'd4;

  localparam logic [1:0] PH_EXPECT = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_NORMAL = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [CodeW-1:0] CODE_CLEAR = 12'd256;
  localparam logic [CodeW-1:0] CODE_END   = 12'd257;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       bytes_pending;
    logic [2:0] status;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       append;
    logic       take;
    logic       set_stat;
    logic [2:0] stat;
    logic       clear_tbl;
    logic       set_done;
    logic       first_lit;
    logic       walk_start;
    logic       walk_step;
    logic       finish;
    logic       pop_rd;
    logic       pop_data;
    logic       emit;
    logic       new_strip;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       stk_empty;
    logic       done;
    logic       have_code;
    logic       ph_expect;
    logic       ph_first;
    logic       is_clear;
    logic       is_end;
    logic       walk_last;
    logic       out_free;
  } sts_t;

endpackage

[hdl/lzw_variable_width_decoder_top.sv]
// top level of the tiff style lzw decoder
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | in_data_i (op, data_byte)
//  out     | output    | out_valid_o/out_ready_i| out_data_o (byte, valid, pending, status)
// a pull of a waiting byte goes from dispatch through the stack ram read states to the result state
// a push appends its byte and decodes; a string code walks the dictionary node by node before the finish state
// one word at a time; the next word is taken while the previous result waits in the output register
// reset clears the bit buffer, stack count and phase; the dictionary needs no clearing
// a stalled output holds the controller in its result state until the register frees
module lzw_variable_width_decoder_top #(
  parameter int TableNodes  = lvwd_pkg::TableNodesDef,
  parameter int MaxCodeBits = lvwd_pkg::MaxCodeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lvwd_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lvwd_pkg::out_word_t out_data_o
);
  import lvwd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lvwd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  lvwd_dpath #(.TableNodes(TableNodes), .MaxCodeBits(MaxCodeBits)) u_dpath (
    .clk_i, .rst_ni, .in_data_i, .out_ready_i, .out_valid_o, .out_data_o,
    .cmd_i(cmd), .sts_o(sts)
  );
endmodule

[hdl/lvwd_ram.sv]
// generic single write, single read ram with registered read
module lvwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/lvwd_dpath.sv]
// datapath: bit buffer, dictionary, string stack and result register
module lvwd_dpath #(
  parameter int TableNodes  = lvwd_pkg::TableNodesDef,
  parameter int MaxCodeBits = lvwd_pkg::MaxCodeBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lvwd_pkg::in_word_t in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output lvwd_pkg::out_word_t out_data_o,
  input  lvwd_pkg::cmd_t     cmd_i,
  output lvwd_pkg::sts_t     sts_o
);
  import lvwd_pkg::*;

  localparam int NodeAw  = $clog2(TableNodes);
  localparam int MaxCode = (1 << MaxCodeBits) - 1;
  localparam int NodeCap = (TableNodes < MaxCode - 1) ? TableNodes : MaxCode - 1;

  logic [1:0]        op_q;
  logic [7:0]        byte_q;
  logic [31:0]       buf_q;
  logic [5:0]        bits_q;
  logic [NodeAw:0]   nf_q;
  logic [CodeW-1:0]  prev_q, code_q, node_q;
  logic [1:0]        phase_q;
  logic [CountW-1:0] cnt_q, idx_q;
  logic              kw_q;
  logic [7:0]        last_q, ob_q;
  logic              obv_q;
  logic [2:0]        stat_q;
  logic              ov_q;
  out_word_t         out_q;

  logic [CountW-1:0] nf13;
  logic [3:0]        w;
  logic [CodeW-1:0]  code_x, code_node, prev_node;
  logic              room, known;
  logic [7:0]        char_rd, stk_rd, wchar, lit;
  logic [NodeAw-1:0] link_rd;
  logic              stk_we;
  logic [StackAw-1:0] stk_wa;
  logic [7:0]        stk_wd;
  logic [5:0]        sh;

  assign nf13 = CountW'(nf_q);
  assign room = nf13 < CountW'(NodeCap);
  assign code_node = (code_q < 12'd256) ? code_q : code_q - 12'd2;
  assign prev_node = (prev_q < 12'd256) ? prev_q : prev_q - 12'd2;
  assign known = (code_q < 12'd256) || (CountW'(code_node) < nf13);
  assign wchar = (node_q < 12'd256) ? node_q[7:0] : char_rd;
  assign lit = (code_q > 12'd255) ? 8'd0 : code_q[7:0];
  assign sh = 6'd24 - bits_q;

  always_comb begin
    if (nf13 <= 13'd508) w = 4'd9;
    else if (nf13 <= 13'd1020) w = 4'd10;
    else if (nf13 <= 13'd2044) w = 4'd11;
    else w = 4'd12;
    if (w > 4'(MaxCodeBits)) w = 4'(MaxCodeBits);
  end

  always_comb begin
    unique case (w)
      4'd9:    code_x = {3'b0, buf_q[31:23]};
      4'd10:   code_x = {2'b0, buf_q[31:22]};
      4'd11:   code_x = {1'b0, buf_q[31:21]};
      default: code_x = buf_q[31:20];
    endcase
  end

  always_comb begin
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = lit;
    if (cmd_i.first_lit) begin
      stk_we = 1'b1;
    end else if (cmd_i.walk_step) begin
      stk_we = 1'b1;
      stk_wa = idx_q[StackAw-1:0];
      stk_wd = wchar;
    end else if (cmd_i.finish && kw_q) begin
      stk_we = 1'b1;
      stk_wd = last_q;
    end
  end

  lvwd_ram #(.Width(8), .Depth(TableNodes)) u_char (
    .clk_i, .we_i(cmd_i.finish && room), .waddr_i(nf_q[NodeAw-1:0]), .wdata_i(last_q),
    .raddr_i(node_q[NodeAw-1:0]), .rdata_o(char_rd)
  );

  lvwd_ram #(.Width(NodeAw), .Depth(TableNodes)) u_link (
    .clk_i, .we_i(cmd_i.finish && room), .waddr_i(nf_q[NodeAw-1:0]),
    .wdata_i(prev_node[NodeAw-1:0]), .raddr_i(node_q[NodeAw-1:0]), .rdata_o(link_rd)
  );

  lvwd_ram #(.Width(8), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(StackAw'(cnt_q - 13'd1)), .rdata_o(stk_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      bits_q  <= '0;
      nf_q    <= (NodeAw+1)'(256);
      prev_q  <= '0;
      phase_q <= PH_EXPECT;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.append && bits_q <= 6'd24) begin
        buf_q  <= buf_q | (32'(byte_q) << sh);
        bits_q <= bits_q + 6'd8;
      end
      if (cmd_i.take) begin
        buf_q  <= buf_q << w;
        bits_q <= bits_q - 6'(w);
      end
      if (cmd_i.clear_tbl) begin
        nf_q    <= (NodeAw+1)'(256);
        phase_q <= PH_FIRST;
      end
      if (cmd_i.set_done) phase_q <= PH_DONE;
      if (cmd_i.first_lit) begin
        cnt_q   <= 13'd1;
        prev_q  <= {4'b0, lit};
        phase_q <= PH_NORMAL;
      end
      if (cmd_i.finish) begin
        cnt_q <= idx_q;
        if (room) nf_q <= nf_q + (NodeAw+1)'(1);
        if (!kw_q) prev_q <= code_q;
        else if (room) prev_q <= CodeW'(nf13 + 13'd2);
      end
      if (cmd_i.pop_rd) cnt_q <= cnt_q - 13'd1;
      if (cmd_i.new_strip) begin
        buf_q   <= '0;
        bits_q  <= '0;
        cnt_q   <= '0;
        nf_q    <= (NodeAw+1)'(256);
        phase_q <= PH_EXPECT;
      end
      if (cmd_i.emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.op;
      byte_q <= in_data_i.data_byte;
      ob_q   <= 8'd0;
      obv_q  <= 1'b0;
      stat_q <= ST_OK;
    end
    if (cmd_i.take) code_q <= code_x;
    if (cmd_i.set_stat) stat_q <= cmd_i.stat;
    if (cmd_i.walk_start) begin
      node_q <= known ? code_node : prev_node;
      idx_q  <= known ? 13'd0 : 13'd1;
      kw_q   <= !known;
    end
    if (cmd_i.walk_step) begin
      last_q <= wchar;
      idx_q  <= idx_q + 13'd1;
      node_q <= CodeW'(link_rd);
    end
    if (cmd_i.pop_data) begin
      ob_q   <= stk_rd;
      obv_q  <= 1'b1;
      stat_q <= ST_OK;
    end
    if (cmd_i.emit) begin
      out_q.out_byte      <= ob_q;
      out_q.out_valid     <= obv_q;
      out_q.bytes_pending <= (cnt_q != '0);
      out_q.status        <= stat_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  assign sts_o.op        = op_q;
  assign sts_o.stk_empty = (cnt_q == '0);
  assign sts_o.done      = (phase_q == PH_DONE);
  assign sts_o.have_code = bits_q >= 6'(w);
  assign sts_o.ph_expect = (phase_q == PH_EXPECT);
  assign sts_o.ph_first  = (phase_q == PH_FIRST);
  assign sts_o.is_clear  = (code_q == CODE_CLEAR);
  assign sts_o.is_end    = (code_q == CODE_END);
  assign sts_o.walk_last = (node_q < 12'd256);
  assign sts_o.out_free  = !ov_q || out_ready_i;
endmodule

[hdl/lvwd_ctrl.sv]
// controller state machine sequencing each word through the datapath
module lvwd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lvwd_pkg::sts_t sts_i,
  output lvwd_pkg::cmd_t cmd_o
);
  import lvwd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_CLS   = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_WWR   = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_AFTER = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_POPD  = 4'd9;
  localparam logic [3:0] S_RES   = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_RES;
        case (sts_i.op)
          OP_PUSH: begin
            if (!sts_i.stk_empty) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat = ST_PENDING;
            end else if (sts_i.done) begin
              cmd_o.set_stat = 1'b1;
              cmd_o.stat = ST_END;
            end else begin
              cmd_o.append = 1'b1;
              state_d = S_DEC;
            end
          end
          OP_PULL: state_d = sts_i.stk_empty ? S_DEC : S_POP;
          OP_STRIP: cmd_o.new_strip = 1'b1;
          default: ;
        endcase
      end
      S_DEC: begin
        cmd_o.set_stat = 1'b1;
        state_d = S_AFTER;
        if (sts_i.done) begin
          cmd_o.stat = ST_END;
        end else if (!sts_i.have_code) begin
          cmd_o.stat = ST_NEED;
        end else begin
          cmd_o.stat = ST_OK;
          cmd_o.take = 1'b1;
          state_d = S_CLS;
        end
      end
      S_CLS: begin
        state_d = S_AFTER;
        if (sts_i.ph_expect) begin
          if (sts_i.is_clear) begin
            cmd_o.clear_tbl = 1'b1;
          end else begin
            cmd_o.set_stat = 1'b1;
            cmd_o.stat = ST_NOCLEAR;
          end
        end else if (sts_i.is_end) begin
          cmd_o.set_done = 1'b1;
          cmd_o.set_stat = 1'b1;
          cmd_o.stat = ST_END;
        end else if (sts_i.is_clear) begin
          cmd_o.clear_tbl = 1'b1;
        end else if (sts_i.ph_first) begin
          cmd_o.first_lit = 1'b1;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d = S_WRD;
        end
      end
      S_WRD: state_d = S_WWR;
      S_WWR: begin
        cmd_o.walk_step = 1'b1;
        state_d = sts_i.walk_last ? S_FIN : S_WRD;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_AFTER;
      end
      S_AFTER: state_d = (sts_i.op == OP_PULL && !sts_i.stk_empty) ? S_POP : S_RES;
      S_POP: begin
        cmd_o.pop_rd = 1'b1;
        state_d = S_POPD;
      end
      S_POPD: begin
        cmd_o.pop_data = 1'b1;
        state_d = S_RES;
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[hdl/lvwd_checker.sv]
// port level checker for the lzw decoder, bound to the top level
`include "lzw_variable_width_decoder_top_assert.svh"

module lvwd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lvwd_pkg::out_word_t out_data_o
);
  import lvwd_pkg::*;

  `LVWD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `LVWD_ASSERT_IMPL(a_byte_ok, out_valid_o && out_data_o.out_valid, out_data_o.status == ST_OK)
  `LVWD_ASSERT_IMPL(a_byte_zero, out_valid_o && !out_data_o.out_valid, out_data_o.out_byte == 8'd0)
  `LVWD_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o, !in_ready_o)
  `LVWD_ASSERT_IMPL(a_status, out_valid_o, out_data_o.status <= ST_PENDING)
endmodule

bind lzw_variable_width_decoder_top lvwd_checker u_chk (.*);

[test/lzw_variable_width_decoder_top_tb.sv]
// self-checking testbench of the lzw decoder top level with a built-in decode predictor
module lzw_variable_width_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lvwd_pkg::*;

  localparam int NodeCap = (TableNodesDef < (1 << MaxCodeBitsDef) - 2) ?
                           TableNodesDef : (1 << MaxCodeBitsDef) - 2;
  localparam logic [12:0] NoLink = 13'h1FFF;
  localparam int CycleLimit = 3000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  lzw_variable_width_decoder_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  dict_char [TableNodesDef];
  logic [12:0] dict_link [TableNodesDef];
  logic [7:0]  str_stack [StackDepth];
  int unsigned stk_cnt, held, free_node, prev_code;
  logic [31:0] bitbuf;
  logic [1:0]  phase;

  out_word_t   word_q[$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  logic [7:0]  strip_bytes[$];

  task automatic report(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function automatic void dict_init();
    for (int i = 0; i < TableNodesDef; i++) begin
      dict_char[i] = (i < 256) ? i[7:0] : 8'd0;
      dict_link[i] = NoLink;
    end
    free_node = 256;
  endfunction

  function automatic int unsigned width_for(input int unsigned nf);
    int unsigned nc, w;
    nc = nf + 2;
    w = 12;
    if (nc <= 510) w = 9;
    else if (nc <= 1022) w = 10;
    else if (nc <= 2046) w = 11;
    if (w > MaxCodeBitsDef) w = MaxCodeBitsDef;
    return w;
  endfunction

  function automatic int unsigned node_of(input int unsigned c);
    return (c < 256) ? c : c - 2;
  endfunction

  function automatic void unwind_str(input int unsigned nd);
    stk_cnt = 0;
    while (nd != NoLink && nd < TableNodesDef && stk_cnt < StackDepth) begin
      str_stack[stk_cnt] = dict_char[nd];
      stk_cnt++;
      nd = dict_link[nd];
    end
  endfunction

  function automatic bit add_node(input int unsigned pc, input logic [7:0] ch);
    if (free_node >= NodeCap) return 1'b0;
    dict_char[free_node] = ch;
    dict_link[free_node] = 13'(node_of(pc));
    free_node++;
    return 1'b1;
  endfunction

  function automatic logic [2:0] decode_code();
    int unsigned w, c, nd;
    logic [7:0] first;
    if (phase == PH_DONE) return ST_END;
    w = width_for(free_node);
    if (held < w) return ST_NEED;
    c = bitbuf >> (32 - w);
    bitbuf = bitbuf << w;
    held -= w;
    if (phase == PH_EXPECT) begin
      if (c != CODE_CLEAR) return ST_NOCLEAR;
      dict_init();
      phase = PH_FIRST;
      return ST_OK;
    end
    if (c == CODE_END) begin
      phase = PH_DONE;
      return ST_END;
    end
    if (c == CODE_CLEAR) begin
      dict_init();
      phase = PH_FIRST;
      return ST_OK;
    end
    if (phase == PH_FIRST) begin
      if (c > 255) c = 0;
      str_stack[0] = c[7:0];
      stk_cnt = 1;
      prev_code = c;
      phase = PH_NORMAL;
      return ST_OK;
    end
    nd = node_of(c);
    if (c < 256 || nd < free_node) begin
      unwind_str(nd);
      first = stk_cnt ? str_stack[stk_cnt-1] : 8'd0;
      void'(add_node(prev_code, first));
      prev_code = c;
    end else begin
      unwind_str(node_of(prev_code));
      first = stk_cnt ? str_stack[stk_cnt-1] : 8'd0;
      if (stk_cnt < StackDepth) begin
        for (int k = stk_cnt; k > 0; k--) str_stack[k] = str_stack[k-1];
        str_stack[0] = first;
        stk_cnt++;
      end
      if (add_node(prev_code, first)) prev_code = free_node + 1;
    end
    prev_code &= 12'hFFF;
    return ST_OK;
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    r = '0;
    if (w.op == OP_PUSH) begin
      if (stk_cnt > 0) r.status = ST_PENDING;
      else if (phase == PH_DONE) r.status = ST_END;
      else begin
        if (held <= 24) begin
          bitbuf |= 32'(w.data_byte) << (24 - held);
          held += 8;
        end
        r.status = decode_code();
      end
    end else if (w.op == OP_PULL) begin
      if (stk_cnt == 0) r.status = decode_code();
      if (stk_cnt > 0 && stk_cnt <= StackDepth) begin
        stk_cnt--;
        r.out_byte = str_stack[stk_cnt];
        r.out_valid = 1'b1;
        r.status = ST_OK;
      end
    end else if (w.op == OP_STRIP) begin
      bitbuf = '0;
      held = 0;
      stk_cnt = 0;
      free_node = 256;
      phase = PH_EXPECT;
    end
    r.bytes_pending = (stk_cnt > 0);
    return r;
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_word);
    out_word_t p;
    p = predict_word(w);
    word_q.push_back(typed ? typed_word : p);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] b);
    in_word_t w;
    w.op = op;
    w.data_byte = b;
    send_word(w, 1'b0, '0);
  endtask

  // msb-first code packer for generated strips
  logic [31:0] pack_acc;
  int unsigned pack_n;

  task automatic pack_code(input int unsigned c, input int unsigned w);
    pack_acc = (pack_acc << w) | c;
    pack_n += w;
    while (pack_n >= 8) begin
      strip_bytes.push_back(8'(pack_acc >> (pack_n - 8)));
      pack_n -= 8;
    end
  endtask

  task automatic build_strip(input int ncodes, input bit lean);
    int unsigned nf, w, c, r;
    bit first;
    strip_bytes.delete();
    pack_acc = '0;
    pack_n = 0;
    nf = 256;
    pack_code(CODE_CLEAR, 9);
    first = 1'b1;
    for (int i = 0; i < ncodes; i++) begin
      w = width_for(nf);
      r = $urandom_range(99);
      if (first) begin
        c = (r < 90) ? $urandom_range(255) : $urandom_range(258, (1 << w) - 1);
        first = 1'b0;
        pack_code(c, w);
        continue;
      end
      if (!lean && r < 3) begin
        pack_code(CODE_CLEAR, w);
        nf = 256;
        first = 1'b1;
        continue;
      end
      if (r < 60 || nf >= NodeCap) c = $urandom_range(255);
      else if (r < 85 && nf > 256) c = $urandom_range(258, nf + 1);
      else if (r < 93 || lean || nf + 3 > (1 << w) - 1) c = nf + 2;
      else c = $urandom_range(nf + 3, (1 << w) - 1);
      pack_code(c, w);
      if (nf < NodeCap) nf++;
    end
    pack_code(CODE_END, width_for(nf));
    if (pack_n > 0)
      strip_bytes.push_back(8'(pack_acc << (8 - pack_n)) |
                            8'($urandom_range((1 << (8 - pack_n)) - 1)));
  endtask

  task automatic run_strip(input int ncodes, input bit lean);
    build_strip(ncodes, lean);
    if ($urandom_range(9) != 0) send_op(OP_STRIP, 8'($urandom_range(255)));
    foreach (strip_bytes[i]) begin
      if (!lean && $urandom_range(99) < 8)
        send_op(2'($urandom_range(3)), 8'($urandom_range(255)));
      while (stk_cnt > 0) send_op(OP_PULL, 8'($urandom_range(255)));
      send_op(OP_PUSH, strip_bytes[i]);
    end
    while (stk_cnt > 0) send_op(OP_PULL, 8'($urandom_range(255)));
    repeat ($urandom_range(2)) send_op(2'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t e;
  } row_t;

  row_t rows[$];

  task automatic add_row(input logic [1:0] op, input logic [7:0] b, input bit typed,
                         input logic [7:0] ob, input logic ov, input logic pend,
                         input logic [2:0] st);
    row_t rw;
    rw.w.op = op;
    rw.w.data_byte = b;
    rw.typed = typed;
    rw.e = '{out_byte: ob, out_valid: ov, bytes_pending: pend, status: st};
    rows.push_back(rw);
  endtask

  // output side
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (word_q.size() == 0) report("result word with nothing expected");
      else begin
        e = word_q.pop_front();
        if (out_data_o.out_byte !== e.out_byte)
          report($sformatf("out_byte %h, expected %h", out_data_o.out_byte, e.out_byte));
        if (out_data_o.out_valid !== e.out_valid)
          report($sformatf("out_valid %b, expected %b", out_data_o.out_valid, e.out_valid));
        if (out_data_o.bytes_pending !== e.bytes_pending)
          report($sformatf("bytes_pending %b, expected %b",
                           out_data_o.bytes_pending, e.bytes_pending));
        if (out_data_o.status !== e.status)
          report($sformatf("status %0d, expected %0d", out_data_o.status, e.status));
      end
    end
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 36);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    dict_init();
    stk_cnt = 0;
    bitbuf = '0;
    held = 0;
    prev_code = 0;
    phase = PH_EXPECT;
    for (int i = 0; i < StackDepth; i++) str_stack[i] = '0;

    add_row(OP_PULL, 8'h00, 1, 8'h00, 0, 0, ST_NEED);
    add_row(2'd3, 8'hAA, 1, 8'h00, 0, 0, ST_OK);
    add_row(OP_PUSH, 8'h00, 1, 8'h00, 0, 0, ST_NEED);
    add_row(OP_STRIP, 8'h55, 1, 8'h00, 0, 0, ST_OK);
    add_row(OP_PUSH, 8'hFF, 1, 8'h00, 0, 0, ST_NEED);
    add_row(OP_PUSH, 8'hFF, 1, 8'h00, 0, 0, ST_NOCLEAR);
    add_row(OP_STRIP, 8'h00, 1, 8'h00, 0, 0, ST_OK);
    add_row(OP_PUSH, 8'h80, 1, 8'h00, 0, 0, ST_NEED);
    add_row(OP_PUSH, 8'h10, 1, 8'h00, 0, 0, ST_OK);
    add_row(OP_PUSH, 8'h60, 1, 8'h00, 0, 1, ST_OK);
    add_row(OP_PUSH, 8'h20, 1, 8'h00, 0, 1, ST_PENDING);
    add_row(OP_PULL, 8'h00, 1, 8'h41, 1, 0, ST_OK);
    add_row(OP_PULL, 8'hFF, 1, 8'h00, 0, 0, ST_NEED);
    add_row(OP_PUSH, 8'h20, 1, 8'h00, 0, 0, ST_END);
    add_row(OP_PUSH, 8'h00, 1, 8'h00, 0, 0, ST_END);
    add_row(OP_PULL, 8'h00, 1, 8'h00, 0, 0, ST_END);
    add_row(OP_STRIP, 8'hFF, 0, 0, 0, 0, ST_OK);
    add_row(OP_PUSH, 8'h80, 0, 0, 0, 0, ST_OK);
    add_row(OP_PUSH, 8'h10, 0, 0, 0, 0, ST_OK);
    add_row(OP_PUSH, 8'hFF, 0, 0, 0, 0, ST_OK);
    add_row(OP_PULL, 8'h00, 0, 0, 0, 0, ST_OK);
    add_row(OP_PULL, 8'h00, 0, 0, 0, 0, ST_OK);
    add_row(2'd3, 8'hFF, 0, 0, 0, 0, ST_OK);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].e);
    in_valid_i <= 1'b0;
    while (word_q.size() != 0) @(posedge clk_i);

    for (int s = 0; s < 6; s++) run_strip($urandom_range(5, 40), 1'b0);
    calm = 1'b1;
    run_strip(280, 1'b1);
    calm = 1'b0;
    for (int s = 0; s < 6; s++) run_strip($urandom_range(5, 40), 1'b0);
    repeat (60) send_op(2'($urandom_range(3)), 8'($urandom_range(255)));

    in_valid_i <= 1'b0;
    while (word_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
